>>> design/assert_macros.svh
// Assertion macros shared by the checker files of the block buffer cache.
// Each macro expands to one labelled concurrent assertion with a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/bbc_pkg.sv
// Package of the block buffer cache: transaction types, codes, search token
// and entry update command. Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package bbc_pkg;

  // Default number of buffer entries and width of an entry index at full range
  localparam int NumBuffersDef = 16;
  localparam int BufIdxW       = 8;

  // Pending list geometry
  localparam int StackDepth = 16;
  localparam int StackAw    = $clog2(StackDepth);
  localparam int CountW     = StackAw + 1;

  // Reference count limit
  localparam logic [7:0] RefMax = 8'hFF;

  // Operation codes
  localparam logic [2:0] OpAcquire  = 3'd0;
  localparam logic [2:0] OpRelease  = 3'd1;
  localparam logic [2:0] OpWrite    = 3'd2;
  localparam logic [2:0] OpPop      = 3'd3;
  localparam logic [2:0] OpComplete = 3'd4;

  // Status codes
  localparam logic [2:0] StatOk      = 3'd0;
  localparam logic [2:0] StatNoFree  = 3'd1;
  localparam logic [2:0] StatBadRel  = 3'd2;
  localparam logic [2:0] StatEmpty   = 3'd3;
  localparam logic [2:0] StatFull    = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  device_id;
    logic [31:0] block_number;
    logic [3:0]  slot;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_out;
    logic       was_hit;
    logic       read_queued;
    logic       start_device;
    logic       popped_dirty;
  } out_t;

  typedef struct packed {
    logic [7:0]  device_id;
    logic [31:0] block_number;
  } tag_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [3:0]         probe;
    logic               hit;
    logic [BufIdxW-1:0] hit_idx;
    logic               hit_valid;
    logic               free;
    logic [BufIdxW-1:0] free_idx;
    logic               probe_cnt_zero;
    logic               probe_dirty;
  } tok_t;

  typedef enum logic [2:0] {
    UpdNone,
    UpdInc,
    UpdClaim,
    UpdDec,
    UpdDirty,
    UpdComplete
  } upd_e;

  // Entry update broadcast to all cells
  typedef struct packed {
    upd_e               kind;
    logic [BufIdxW-1:0] idx;
    tag_t               tag;
  } upd_t;

  typedef enum logic [1:0] {
    StIdle,
    StLaunch,
    StScan,
    StDone
  } state_e;

endpackage

>>> design/bbc_cell.sv
// One buffer entry of the block buffer cache: tag, reference count and marks,
// plus one stage of the search token chain. Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_cell import bbc_pkg::*; #(
  parameter int Index = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  tag_t key_i,
  input  tok_t tok_i,
  output tok_t tok_o,
  input  upd_t upd_i
);

  localparam logic [BufIdxW-1:0] CellIdx = BufIdxW'(Index);

  tag_t       tag_q, tag_d;
  logic [7:0] cnt_q, cnt_d;
  logic       valid_q, valid_d;
  logic       dirty_q, dirty_d;
  tok_t       tok_q, tok_d;

  // Fold this entry into the passing token
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && tag_q == key_i) begin
      tok_d.hit       = 1'b1;
      tok_d.hit_idx   = CellIdx;
      tok_d.hit_valid = valid_q;
    end
    if (!tok_i.free && cnt_q == 8'd0) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = CellIdx;
    end
    if (BufIdxW'(tok_i.probe) == CellIdx) begin
      tok_d.probe_cnt_zero = (cnt_q == 8'd0);
      tok_d.probe_dirty    = dirty_q;
    end
  end

  // Apply a broadcast update addressed to this entry
  always_comb begin
    tag_d   = tag_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    if (upd_i.idx == CellIdx) begin
      case (upd_i.kind)
        UpdInc: begin
          if (cnt_q != RefMax) cnt_d = cnt_q + 8'd1;
        end
        UpdClaim: begin
          tag_d   = upd_i.tag;
          cnt_d   = 8'd1;
          valid_d = 1'b0;
          dirty_d = 1'b0;
        end
        UpdDec: begin
          cnt_d = cnt_q - 8'd1;
          if (cnt_q == 8'd1) begin
            valid_d = 1'b0;
            dirty_d = 1'b0;
          end
        end
        UpdDirty: begin
          dirty_d = 1'b1;
        end
        UpdComplete: begin
          valid_d = 1'b1;
          dirty_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tag_q   <= tag_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> design/bbc_stack.sv
// Pending I/O list of the block buffer cache: a LIFO of entry numbers held in
// a small memory with a fill count and a registered read. Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_stack import bbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [3:0]        push_data_i,
  input  logic              pop_i,
  output logic [CountW-1:0] count_o,
  output logic              full_o,
  output logic [3:0]        rd_data_o
);

  logic [3:0]        mem [StackDepth];
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] count_m1;
  logic [3:0]        rd_q;

  assign count_m1 = count_q - CountW'(1);
  assign full_o   = (count_q == CountW'(StackDepth));

  // Advance the fill count
  always_comb begin
    count_d = count_q;
    if (push_i && !full_o) begin
      count_d = count_q + CountW'(1);
    end else if (pop_i && count_q != '0) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Write on push, read the top entry on pop
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem[count_q[StackAw-1:0]] <= push_data_i;
    end
    if (pop_i && count_q != '0) begin
      rd_q <= mem[count_m1[StackAw-1:0]];
    end
  end

  assign count_o   = count_q;
  assign rd_data_o = rd_q;

endmodule

>>> design/block_buffer_cache_with_io_stack_unit.sv
// Block buffer cache with pending I/O list. One transaction at a time: the
// search token is launched into the row of entry cells and moves one cell per
// cycle, and the result then passes through the result register and the
// output register.
// in_stall_o is high from acceptance until the result is loaded into the
// output register; a result left waiting there does not hold off the next
// transaction. There is no clearing pass after reset. Depends on bbc_pkg,
// bbc_cell and bbc_stack.
`timescale 1ns / 1ps

module block_buffer_cache_with_io_stack_unit import bbc_pkg::*; #(
  parameter int NumBuffers = NumBuffersDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  state_e state_q, state_d;
  in_t    item_q;
  logic   pop_empty_q;
  out_t   res_q, res_d;
  out_t   out_q;
  logic   out_valid_q;

  logic   accept;
  logic   exec;
  logic   load;
  logic   slot_ok;

  tok_t   chain [NumBuffers+1];
  tok_t   launch_tok;
  upd_t   upd;
  tag_t   key;

  logic              push;
  logic [3:0]        push_data;
  logic              pop;
  logic [CountW-1:0] st_count;
  logic              st_full;
  logic [3:0]        st_rd;

  assign accept  = in_valid_i && (state_q == StIdle);
  assign slot_ok = {28'd0, item_q.slot} < 32'(NumBuffers);
  assign key     = '{device_id: item_q.device_id, block_number: item_q.block_number};
  assign exec    = (state_q == StScan) && chain[NumBuffers].valid;
  assign load    = (state_q == StDone) && (!out_valid_q || !out_stall_i);
  assign pop     = accept && in_data_i.operation == OpPop && st_count != '0;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (accept) state_d = StLaunch;
      StLaunch: state_d = StScan;
      StScan:   if (exec) state_d = StDone;
      StDone:   if (load) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Launch the search token; a pop probes the entry just read from the list
  always_comb begin
    launch_tok       = '0;
    launch_tok.valid = (state_q == StLaunch);
    launch_tok.probe = (item_q.operation == OpPop) ? st_rd : item_q.slot;
  end

  assign chain[0] = launch_tok;

  // Decide the update, the push and the result once the token is back
  always_comb begin
    tok_t               t;
    logic [BufIdxW-1:0] tgt;
    logic               tvalid;
    logic               have;
    t         = chain[NumBuffers];
    tgt       = '0;
    tvalid    = 1'b0;
    have      = 1'b0;
    upd       = '{kind: UpdNone, idx: BufIdxW'(item_q.slot), tag: key};
    push      = 1'b0;
    push_data = item_q.slot;
    res_d     = res_q;
    if (exec) begin
      res_d = '0;
      case (item_q.operation)
        OpAcquire: begin
          if (t.hit) begin
            tgt      = t.hit_idx;
            tvalid   = t.hit_valid;
            have     = 1'b1;
            upd.kind = UpdInc;
          end else if (t.free) begin
            tgt      = t.free_idx;
            have     = 1'b1;
            upd.kind = UpdClaim;
          end else begin
            res_d.status = StatNoFree;
          end
          upd.idx = tgt;
          if (have) begin
            res_d.slot_out = 4'(tgt);
            res_d.was_hit  = t.hit;
            if (!tvalid) begin
              push_data = 4'(tgt);
              if (st_full) begin
                res_d.status = StatFull;
              end else begin
                push               = 1'b1;
                res_d.read_queued  = 1'b1;
                res_d.start_device = (st_count == '0);
              end
            end
          end
        end
        OpRelease: begin
          if (!slot_ok || t.probe_cnt_zero) begin
            res_d.status = StatBadRel;
          end else begin
            upd.kind = UpdDec;
          end
        end
        OpWrite: begin
          if (slot_ok) begin
            upd.kind = UpdDirty;
            if (st_full) begin
              res_d.status = StatFull;
            end else begin
              push               = 1'b1;
              res_d.start_device = (st_count == '0);
            end
          end
        end
        OpPop: begin
          if (pop_empty_q) begin
            res_d.status = StatEmpty;
          end else begin
            res_d.slot_out     = st_rd;
            res_d.popped_dirty = t.probe_dirty;
          end
        end
        OpComplete: begin
          if (slot_ok) upd.kind = UpdComplete;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load || (out_valid_q && out_stall_i);
    end
  end

  // Hold the transaction, the pending result and the output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q      <= in_data_i;
      pop_empty_q <= (st_count == '0);
    end
    res_q <= res_d;
    if (load) out_q <= res_q;
  end

  // Row of entry cells
  for (genvar i = 0; i < NumBuffers; i++) begin : g_cell
    bbc_cell #(
      .Index(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .key_i (key),
      .tok_i (chain[i]),
      .tok_o (chain[i+1]),
      .upd_i (upd)
    );
  end

  bbc_stack u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .count_o    (st_count),
    .full_o     (st_full),
    .rd_data_o  (st_rd)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/bbc_checker.sv
// Port-level checker for the block buffer cache, bound to the top level.
// Depends on bbc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bbc_checker import bbc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // Hold a stalled result
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Block stays busy in the cycle after taking a transaction
  `ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A queued read or a device start only comes with a successful push
  `ASSERT_IMP(a_push_ok, clk_i, rst_ni, out_valid_o && (out_data_o.read_queued || out_data_o.start_device), out_data_o.status == StatOk)

  // A hit comes only from an acquire, which ends ok or with a full list
  `ASSERT_IMP(a_hit_status, clk_i, rst_ni, out_valid_o && out_data_o.was_hit, out_data_o.status == StatOk || out_data_o.status == StatFull)

endmodule

bind block_buffer_cache_with_io_stack_unit bbc_checker u_bbc_checker (.*);

>>> dv/block_buffer_cache_with_io_stack_unit_test.sv
// Self-checking testbench for the block buffer cache with its pending I/O list.
// Holds its own copy of the tag table and the pending list to predict results.
// Depends on bbc_pkg and block_buffer_cache_with_io_stack_unit.
`timescale 1ns / 1ps

module block_buffer_cache_with_io_stack_unit_test;
  import bbc_pkg::*;

  localparam int NumSlots   = NumBuffersDef;
  localparam int NumDirRows = 21;
  localparam int RandomReqs = 500;
  localparam int DrainWait  = 3 * (NumSlots + 3);

  // Operation codes the block does not decode
  localparam logic [2:0] OpSpare5 = 3'd5;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  typedef struct packed {
    in_t  req;
    logic known;
    out_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // Mirror of the cache table and the pending list
  logic [7:0]  cache_dev   [NumSlots];
  logic [31:0] cache_blk   [NumSlots];
  logic [7:0]  cache_cnt   [NumSlots];
  logic        cache_valid [NumSlots];
  logic        cache_dirty [NumSlots];
  logic [3:0]  pend_list   [StackDepth];
  int          pend_depth;

  out_t     due_results[$];
  dir_row_t dir_rows [NumDirRows];
  int       mismatch_count = 0;
  int       requests_sent  = 0;
  int       out_phase_left = 0;
  logic     out_hold       = 1'b0;

  block_buffer_cache_with_io_stack_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t make_req(logic [2:0] op, logic [7:0] dev, logic [31:0] blk,
                                   logic [3:0] slot);
    in_t req;
    req.operation    = op;
    req.device_id    = dev;
    req.block_number = blk;
    req.slot         = slot;
    return req;
  endfunction

  // Push an entry on the pending list; return 0 when the list is full
  function automatic bit push_pending(logic [3:0] e);
    if (pend_depth >= StackDepth) return 1'b0;
    pend_list[pend_depth] = e;
    pend_depth++;
    return 1'b1;
  endfunction

  // Apply one request to the mirror and return the result it gives
  function automatic out_t apply_request(in_t req);
    out_t res;
    int   idx;
    bit   found;
    bit   slot_ok;
    res     = '0;
    idx     = 0;
    found   = 1'b0;
    slot_ok = int'(req.slot) < NumSlots;
    res.status = StatOk;
    case (req.operation)
      OpAcquire: begin
        // tag search over every entry, whatever its count
        for (int i = 0; i < NumSlots; i++) begin
          if (!found && cache_dev[i] == req.device_id && cache_blk[i] == req.block_number) begin
            idx   = i;
            found = 1'b1;
          end
        end
        if (found) begin
          res.was_hit = 1'b1;
          if (cache_cnt[idx] != RefMax) cache_cnt[idx]++;
        end else begin
          // claim the lowest free entry
          for (int i = 0; i < NumSlots; i++) begin
            if (!found && cache_cnt[i] == 8'd0) begin
              idx   = i;
              found = 1'b1;
            end
          end
          if (found) begin
            cache_cnt[idx]   = 8'd1;
            cache_dev[idx]   = req.device_id;
            cache_blk[idx]   = req.block_number;
            cache_valid[idx] = 1'b0;
            cache_dirty[idx] = 1'b0;
          end else begin
            res.status = StatNoFree;
          end
        end
        if (found) begin
          res.slot_out = idx[3:0];
          if (!cache_valid[idx]) begin
            if (push_pending(idx[3:0])) begin
              res.read_queued  = 1'b1;
              res.start_device = pend_depth == 1;
            end else begin
              res.status = StatFull;
            end
          end
        end
      end
      OpRelease: begin
        if (!slot_ok || cache_cnt[req.slot] == 8'd0) begin
          res.status = StatBadRel;
        end else begin
          cache_cnt[req.slot]--;
          if (cache_cnt[req.slot] == 8'd0) begin
            cache_valid[req.slot] = 1'b0;
            cache_dirty[req.slot] = 1'b0;
          end
        end
      end
      OpWrite: begin
        if (slot_ok) begin
          cache_dirty[req.slot] = 1'b1;
          if (push_pending(req.slot)) res.start_device = pend_depth == 1;
          else res.status = StatFull;
        end
      end
      OpPop: begin
        if (pend_depth == 0) begin
          res.status = StatEmpty;
        end else begin
          pend_depth--;
          res.slot_out = pend_list[pend_depth];
          if (int'(res.slot_out) < NumSlots) res.popped_dirty = cache_dirty[res.slot_out];
        end
      end
      OpComplete: begin
        if (slot_ok) begin
          cache_valid[req.slot] = 1'b1;
          cache_dirty[req.slot] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offer one transaction, hold it until accepted, then log its result
  task automatic send_request(input in_t req, input logic known, input out_t want);
    out_t pred;
    int   gap;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pred = apply_request(req);
    due_results.push_back(known ? want : pred);
    if (req.operation <= OpComplete) requests_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send(input in_t req);
    send_request(req, 1'b0, '0);
  endtask

  // Pick an entry that holds a reference, starting at a random point
  function automatic logic [3:0] busy_slot();
    int base;
    base = $urandom_range(0, NumSlots - 1);
    for (int k = 0; k < NumSlots; k++) begin
      if (cache_cnt[(base + k) % NumSlots] != 8'd0) return 4'((base + k) % NumSlots);
    end
    return 4'(base);
  endfunction

  task automatic acquire_fresh();
    logic [7:0]  dev;
    logic [31:0] blk;
    dev = 8'($urandom_range(0, 255));
    blk = $urandom();
    case ($urandom_range(0, 9))
      0: dev = 8'h00;
      1: dev = 8'hFF;
      2: blk = 32'hFFFF_FFFF;
      default: ;
    endcase
    send(make_req(OpAcquire, dev, blk, 4'($urandom_range(0, 15))));
  endtask

  task automatic acquire_live();
    logic [3:0] s;
    s = 4'($urandom_range(0, NumSlots - 1));
    send(make_req(OpAcquire, cache_dev[s], cache_blk[s], 4'($urandom_range(0, 15))));
  endtask

  // One request drawn from a typical operation mix
  task automatic send_mixed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) acquire_live();
    else if (r < 35) acquire_fresh();
    else if (r < 55) begin
      if ($urandom_range(0, 4) != 0) send(make_req(OpRelease, 8'($urandom), $urandom,
                                                   busy_slot()));
      else send(make_req(OpRelease, 8'($urandom), $urandom, 4'($urandom_range(0, 15))));
    end
    else if (r < 68) send(make_req(OpWrite, 8'($urandom), $urandom,
                                   4'($urandom_range(0, 15))));
    else if (r < 82) send(make_req(OpPop, 8'($urandom), $urandom, 4'($urandom_range(0, 15))));
    else if (r < 95) send(make_req(OpComplete, 8'($urandom), $urandom, busy_slot()));
    else send(make_req(3'($urandom_range(OpSpare5, OpSpare7)), 8'($urandom), $urandom,
                       4'($urandom_range(0, 15))));
  endtask

  // Drive the reference count of one entry into saturation
  task automatic hammer_entry();
    logic [3:0]  s;
    logic [7:0]  dev;
    logic [31:0] blk;
    int          h;
    s   = 4'($urandom_range(0, NumSlots - 1));
    dev = cache_dev[s];
    blk = cache_blk[s];
    h   = int'(s);
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (cache_dev[i] == dev && cache_blk[i] == blk) h = i;
    end
    send(make_req(OpComplete, 8'h00, 32'h0, 4'(h)));
    repeat (258) send(make_req(OpAcquire, dev, blk, 4'($urandom_range(0, 15))));
  endtask

  task automatic run_random_phase();
    int  m;
    bit  hammered;
    hammered = 1'b0;
    while (requests_sent < RandomReqs + NumDirRows) begin
      m = $urandom_range(0, 99);
      if (!hammered && requests_sent > 150) begin
        hammer_entry();
        hammered = 1'b1;
      end else if (m < 50) begin
        send_mixed();
      end else if (m < 60) begin
        // fill the table until no entry is free
        repeat (18) acquire_fresh();
      end else if (m < 70) begin
        // empty the list, then pop once more
        while (pend_depth > 0) send(make_req(OpPop, 8'($urandom), $urandom, 4'($urandom)));
        send(make_req(OpPop, 8'($urandom), $urandom, 4'($urandom)));
      end else if (m < 80) begin
        for (int i = 0; i < NumSlots; i++) begin
          if (cache_cnt[i] != 8'd0) send(make_req(OpRelease, 8'($urandom), $urandom, 4'(i)));
        end
      end else if (m < 88) begin
        // overflow the pending list with writes
        repeat (17) send(make_req(OpWrite, 8'($urandom), $urandom,
                                  4'($urandom_range(0, 15))));
      end else if (m < 95) begin
        repeat (3) send(make_req(3'($urandom_range(0, 7)), 8'($urandom), $urandom,
                                 4'($urandom)));
      end else begin
        acquire_live();
        send(make_req(OpComplete, 8'($urandom), $urandom, busy_slot()));
      end
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare a delivered transaction with the oldest expectation
  task automatic check_result(input out_t got);
    out_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      mismatch_count++;
    end else begin
      want = due_results.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
      check_field("was_hit", 32'(want.was_hit), 32'(got.was_hit));
      check_field("read_queued", 32'(want.read_queued), 32'(got.read_queued));
      check_field("start_device", 32'(want.start_device), 32'(got.start_device));
      check_field("popped_dirty", 32'(want.popped_dirty), 32'(got.popped_dirty));
    end
  endtask

  // Sample results and vary the output stall in runs and bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
    if (out_phase_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        out_hold       = 1'b0;
        out_phase_left = $urandom_range(20, 150);
      end else begin
        out_hold       = !out_hold;
        out_phase_left = out_hold ? idle_len() : $urandom_range(1, 8);
      end
    end else begin
      out_phase_left--;
    end
    out_stall_i <= out_hold;
  end

  // Directed rows, then random sequences, then drain and report
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    for (int i = 0; i < NumSlots; i++) begin
      cache_dev[i]   = '0;
      cache_blk[i]   = '0;
      cache_cnt[i]   = '0;
      cache_valid[i] = 1'b0;
      cache_dirty[i] = 1'b0;
    end
    for (int i = 0; i < StackDepth; i++) pend_list[i] = '0;
    pend_depth = 0;

    dir_rows = '{
      // reset tags: (0,0) hits entry 0, which is not valid, so it is queued
      '{'{OpAcquire, 8'h00, 32'h0000_0000, 4'd0}, 1'b1,
        '{StatOk, 4'd0, 1'b1, 1'b1, 1'b1, 1'b0}},
      '{'{OpWrite, 8'h00, 32'h0000_0000, 4'd0}, 1'b1, '{StatOk, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OpPop, 8'h00, 32'h0000_0000, 4'd0}, 1'b1, '{StatOk, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{OpPop, 8'hFF, 32'hFFFF_FFFF, 4'd15}, 1'b1, '{StatOk, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{OpPop, 8'h00, 32'h0000_0000, 4'd0}, 1'b1, '{StatEmpty, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OpRelease, 8'h00, 32'h0000_0000, 4'd15}, 1'b1,
        '{StatBadRel, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OpComplete, 8'h00, 32'h0000_0000, 4'd0}, 1'b1, '{StatOk, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OpAcquire, 8'h00, 32'h0000_0000, 4'd15}, 1'b1,
        '{StatOk, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{'{OpAcquire, 8'hFF, 32'hFFFF_FFFF, 4'd0}, 1'b1,
        '{StatOk, 4'd1, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{'{OpAcquire, 8'hAA, 32'h5555_5555, 4'd0}, 1'b0, '0},
      '{'{OpAcquire, 8'h55, 32'hAAAA_AAAA, 4'd0}, 1'b0, '0},
      // write to an entry that holds no reference still pushes it
      '{'{OpWrite, 8'h00, 32'h0000_0000, 4'd15}, 1'b0, '0},
      '{'{OpRelease, 8'h00, 32'h0000_0000, 4'd0}, 1'b0, '0},
      '{'{OpRelease, 8'h00, 32'h0000_0000, 4'd0}, 1'b0, '0},
      '{'{OpRelease, 8'h00, 32'h0000_0000, 4'd0}, 1'b1,
        '{StatBadRel, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // a stale tag on a free entry still hits
      '{'{OpAcquire, 8'h00, 32'h0000_0000, 4'd0}, 1'b0, '0},
      '{'{OpSpare5, 8'hFF, 32'hFFFF_FFFF, 4'd15}, 1'b1, '{StatOk, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OpSpare6, 8'hFF, 32'hFFFF_FFFF, 4'd15}, 1'b1, '{StatOk, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OpSpare7, 8'hFF, 32'hFFFF_FFFF, 4'd15}, 1'b1, '{StatOk, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{OpComplete, 8'h00, 32'h0000_0000, 4'd15}, 1'b0, '0},
      '{'{OpPop, 8'h00, 32'h0000_0000, 4'd0}, 1'b0, '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      send_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
    end
    run_random_phase();
    in_valid_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/bbc_pkg.sv
design/bbc_cell.sv
design/bbc_stack.sv
design/block_buffer_cache_with_io_stack_unit.sv
design/bbc_checker.sv
dv/block_buffer_cache_with_io_stack_unit_test.sv
